// ===== rtl/core/wtg_pkg.sv =====
// Shared types, constants and register map of the warble tone generator.
package wtg_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int STEP_W      = 32;
  localparam int RATIO_W     = 32;
  localparam int SAMPLE_W    = 15;
  localparam int HPS_W       = 16;
  localparam int HPL_W       = 8;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [RATIO_W-1:0] ONE_Q30 = 32'h4000_0000;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RISE = 2'd1,
    MODE_FALL = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_STEP_LOW     = 3'd0,
    REG_STEP_HIGH    = 3'd1,
    REG_UP_RATIO     = 3'd2,
    REG_DOWN_RATIO   = 3'd3,
    REG_GLIDE_ENABLE = 3'd4,
    REG_HALF_SAMPLES = 3'd5,
    REG_HALF_LIMIT   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_low;
    logic [STEP_W-1:0]  step_high;
    logic [RATIO_W-1:0] up_ratio;
    logic [30:0]        down_ratio;
    logic               glide_enable;
    logic [HPS_W-1:0]   half_period_samples;
    logic [HPL_W-1:0]   half_period_limit;
  } cfg_t;

  typedef struct packed {
    logic                       active;
    logic signed [SAMPLE_W-1:0] sample;
  } res_t;

endpackage

// ===== rtl/core/warble_tone_generator.sv =====
// Top level of the warble tone generator: config port, oscillator core and result register.
//
// Input stream: one transaction per item. in_tuser is the function (0 tick,
// 1 trigger), in_tdata[1:0] the trigger mode (0 idle, 1 rising, 2 falling).
// A tick yields the next sawtooth sample; a trigger loads the start step and
// glide ratio and yields a zero sample.
// Output stream: exactly one transaction per input item, in order.
// out_tdata[14:0] is the signed sample, out_tdata[15] the active flag.
// Latency: the result is valid in the cycle after the input transaction.
// Throughput: one item per cycle unless the output stalls; the oscillator
// state updates in the same cycle the item is taken (one 32x32 multiply,
// a clamp compare and the half-period counters).
// Stall: the result register holds until taken; in_tready stays high while
// out_tready is high or the result register is empty, so no result is lost.
// Reset: mode idle, phase and step zero, ratio 1.0, registers at defaults,
// result register empty. Write registers over APB only while idle.
module warble_tone_generator import wtg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] trigger_mode, rest zero
  input  logic                   in_tuser,   // [0] func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [14:0] sample, [15] active
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t cfg;
  res_t res;
  res_t out_r;
  logic out_valid_r, out_valid_nxt;
  logic in_accept;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  wtg_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  wtg_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .accept       (in_accept),
    .func         (in_tuser),
    .trigger_mode (in_tdata[1:0]),
    .res          (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_accept) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.active, out_r.sample};

endmodule

// ===== rtl/core/wtg_cfg_regs.sv =====
// APB-style configuration register file of the warble tone generator.
module wtg_cfg_regs import wtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_STEP_LOW:     cfg_nxt.step_low            = cfg_pwdata;
        REG_STEP_HIGH:    cfg_nxt.step_high           = cfg_pwdata;
        REG_UP_RATIO:     cfg_nxt.up_ratio            = cfg_pwdata;
        REG_DOWN_RATIO:   cfg_nxt.down_ratio          = cfg_pwdata[30:0];
        REG_GLIDE_ENABLE: cfg_nxt.glide_enable        = cfg_pwdata[0];
        REG_HALF_SAMPLES: cfg_nxt.half_period_samples = cfg_pwdata[HPS_W-1:0];
        REG_HALF_LIMIT:   cfg_nxt.half_period_limit   = cfg_pwdata[HPL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_STEP_LOW:     cfg_prdata = cfg_r.step_low;
      REG_STEP_HIGH:    cfg_prdata = cfg_r.step_high;
      REG_UP_RATIO:     cfg_prdata = cfg_r.up_ratio;
      REG_DOWN_RATIO:   cfg_prdata = {1'b0, cfg_r.down_ratio};
      REG_GLIDE_ENABLE: cfg_prdata = {31'd0, cfg_r.glide_enable};
      REG_HALF_SAMPLES: cfg_prdata = {16'd0, cfg_r.half_period_samples};
      REG_HALF_LIMIT:   cfg_prdata = {24'd0, cfg_r.half_period_limit};
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_low            <= 32'd42852281;
      cfg_r.step_high           <= 32'd85704562;
      cfg_r.up_ratio            <= ONE_Q30;
      cfg_r.down_ratio          <= ONE_Q30[30:0];
      cfg_r.glide_enable        <= 1'b1;
      cfg_r.half_period_samples <= 16'd22050;
      cfg_r.half_period_limit   <= 8'd20;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/wtg_core.sv =====
// Oscillator state and one-pass update: phase, step glide, clamps and half-period counting.
module wtg_core import wtg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic       func,
  input  logic [1:0] trigger_mode,
  output res_t       res
);

  mode_t                 mode_r, mode_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [RATIO_W-1:0]    ratio_r, ratio_nxt;
  logic [HPS_W-1:0]      sc_r, sc_nxt;
  logic [HPL_W-1:0]      hpc_r, hpc_nxt;

  logic [STEP_W+RATIO_W-1:0]  prod;
  logic [STEP_W-1:0]          prod_sat;
  logic [PHASE_BITS+31:0]     step_wide;
  logic [PHASE_BITS-1:0]      inc;
  logic                       running, rising, clamp_hi, clamp_lo;
  logic [HPS_W-1:0]           sc_inc;
  logic [HPL_W-1:0]           hpc_inc;
  logic                       half_end, last_half;
  logic [RATIO_W-1:0]         down_ratio_ext;
  logic [SAMPLE_W-1:0]        saw;

  // align the Q0.32 step to the phase width by its top bits
  assign step_wide = {step_r, PHASE_BITS'(0)};
  assign inc       = step_wide[PHASE_BITS+31 -: PHASE_BITS];

  assign prod     = step_r * ratio_r;
  assign prod_sat = (|prod[STEP_W+RATIO_W-1 -: 2]) ? '1 : prod[STEP_W+29:30];

  assign running   = (mode_r == MODE_RISE) || (mode_r == MODE_FALL);
  assign rising    = (mode_r == MODE_RISE);
  assign clamp_hi  = rising && (prod_sat > cfg.step_high);
  assign clamp_lo  = (mode_r == MODE_FALL) && (prod_sat < cfg.step_low);
  assign sc_inc    = sc_r + 1'b1;
  assign hpc_inc   = hpc_r + 1'b1;
  assign half_end  = sc_inc >= cfg.half_period_samples;
  assign last_half = hpc_inc == cfg.half_period_limit;

  assign down_ratio_ext = {1'b0, cfg.down_ratio};
  // top phase bits minus half scale: flip the sign bit
  assign saw = {~phase_r[PHASE_BITS-1], phase_r[PHASE_BITS-2 -: SAMPLE_W-1]};

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (accept) begin
      if (func) begin
        case (trigger_mode)
          MODE_RISE: mode_nxt = MODE_RISE;
          MODE_FALL: mode_nxt = MODE_FALL;
          default:   mode_nxt = MODE_IDLE;
        endcase
      end else if (running) begin
        if (half_end) begin
          if (last_half) mode_nxt = MODE_IDLE;
          else if (rising) mode_nxt = MODE_FALL;
          else mode_nxt = MODE_RISE;
        end
      end else begin
        mode_nxt = MODE_IDLE;
      end
    end
  end

  // datapath and counters
  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    ratio_nxt = ratio_r;
    sc_nxt    = sc_r;
    hpc_nxt   = hpc_r;
    if (accept) begin
      if (func) begin
        sc_nxt  = '0;
        hpc_nxt = '0;
        case (trigger_mode)
          MODE_RISE: begin
            step_nxt  = cfg.step_low;
            ratio_nxt = cfg.glide_enable ? cfg.up_ratio : ONE_Q30;
          end
          MODE_FALL: begin
            step_nxt  = cfg.step_high;
            ratio_nxt = cfg.glide_enable ? down_ratio_ext : ONE_Q30;
          end
          default: begin
            phase_nxt = '0;
            step_nxt  = '0;
            ratio_nxt = ONE_Q30;
          end
        endcase
      end else begin
        phase_nxt = phase_r + inc;
        step_nxt  = prod_sat;
        if (clamp_hi) begin
          step_nxt  = cfg.step_high;
          ratio_nxt = ONE_Q30;
        end else if (clamp_lo) begin
          step_nxt  = cfg.step_low;
          ratio_nxt = ONE_Q30;
        end
        if (running) begin
          sc_nxt = sc_inc;
          if (half_end) begin
            sc_nxt  = '0;
            hpc_nxt = hpc_inc;
            if (!last_half) begin
              if (cfg.glide_enable) begin
                ratio_nxt = rising ? down_ratio_ext : cfg.up_ratio;
              end else begin
                step_nxt  = rising ? cfg.step_low : cfg.step_high;
                ratio_nxt = ONE_Q30;
              end
            end
          end
        end
      end
    end
  end

  // result outputs
  always_comb begin
    res.sample = '0;
    if (!func && running) res.sample = saw;
    res.active = (mode_nxt != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      phase_r <= '0;
      step_r  <= '0;
      ratio_r <= ONE_Q30;
      sc_r    <= '0;
      hpc_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      ratio_r <= ratio_nxt;
      sc_r    <= sc_nxt;
      hpc_r   <= hpc_nxt;
    end
  end

endmodule
